### sv/aspq_pkg.sv
// ----------------------------------------------------------------------------
// Aging sorted priority queue package
// Shared field widths, operation and status codes, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package aspq_pkg;

   localparam int MODE_W      = 2;
   localparam int IO_TAG_W    = 8;
   localparam int PRIO_W      = 16;
   localparam int TIME_W      = 16;
   localparam int COUNT_W     = 5;
   localparam int SUM_W       = 20;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_PAD_W   = RSP_DATA_W - (IO_TAG_W + PRIO_W + TIME_W + COUNT_W + SUM_W);

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_W-1:0] OP_PUSH_START = 4'd2;
   localparam logic [OP_W-1:0] OP_PUSH_STEP  = 4'd3;
   localparam logic [OP_W-1:0] OP_SRCH_START = 4'd4;
   localparam logic [OP_W-1:0] OP_SRCH_STEP  = 4'd5;
   localparam logic [OP_W-1:0] OP_AGE_START  = 4'd6;
   localparam logic [OP_W-1:0] OP_AGE_STEP   = 4'd7;
   localparam logic [OP_W-1:0] OP_FINISH     = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              empty;
      logic              full;
      logic              push_done;
      logic              found;
      logic              walk_end;
      logic              pos_zero;
      logic              age_end;
      logic              out_busy;
   } stat_type;

endpackage

### sv/aging_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Aging sorted priority queue unit
// Holds up to DEPTH entries sorted by ascending priority and serves push,
// pop, remove by tag and peek requests, aging the remaining entries on every
// pop or remove that takes an entry out.
//
//   Channel   Direction  Fields
//   req_*     in         tuser: mode; tdata: tag, priority, service time
//   rsp_*     out        tuser: status; tdata: tag, priority, time, count, total
//
// One request is in progress at a time. A push walks from the tail down to its
// insertion slot, shifting entries up; a pop or remove searches the whole queue,
// shifting and aging the entries behind the found slot, then ages those before
// it; a peek stops at the head; a dropped push or a request to an empty queue
// goes straight to the result, and the next request waits for its hand-off.
// Reset is synchronous and empties the queue; a result not taken stalls the next.
// ----------------------------------------------------------------------------
module aging_sorted_priority_queue_unit #(
   parameter int DEPTH    = 16,
   parameter int TAG_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] entry_tag, [23:8] entry_priority, [39:24] service_time
   input  logic [aspq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] mode
   input  logic [aspq_pkg::MODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] head_tag, [23:8] head_priority, [39:24] head_time,
   // [44:40] entry_count, [64:45] total_time, [71:65] zero
   output logic [aspq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [aspq_pkg::STATUS_W-1:0]       rsp_tuser
);
   import aspq_pkg::*;

   cmd_type             cmd;
   stat_type            st;
   logic [IO_TAG_W-1:0] out_tag;
   logic [PRIO_W-1:0]   out_priority;
   logic [TIME_W-1:0]   out_time;
   logic [COUNT_W-1:0]  out_count;
   logic [SUM_W-1:0]    out_total;

   aspq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   aspq_datapath #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .in_mode      (req_tuser),
      .in_tag       (req_tdata[7:0]),
      .in_priority  (req_tdata[23:8]),
      .in_time      (req_tdata[39:24]),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_status   (rsp_tuser),
      .out_tag      (out_tag),
      .out_priority (out_priority),
      .out_time     (out_time),
      .out_count    (out_count),
      .out_total    (out_total)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_total, out_count, out_time, out_priority, out_tag};

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction was still in progress");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) |=> rsp_tvalid)
      else $error("finished transaction did not reach the output register");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      st.full |-> !st.empty)
      else $error("queue reported both full and empty");

   a_no_push_walk_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH_START) |-> !st.full)
      else $error("insertion walk started on a full queue");
`endif

endmodule

### sv/aspq_ctrl.sv
// ----------------------------------------------------------------------------
// Aging sorted priority queue controller
// Sequences decode, the insertion walk, the search and shift walk, the aging
// walk and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module aspq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  aspq_pkg::stat_type st,
   output aspq_pkg::cmd_type  cmd
);
   import aspq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_PUSH   = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_AGE    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [STATUS_W-1:0] fin_status_ff;
   logic [STATUS_W-1:0] fin_status_in;

   always_comb begin
      state_in      = state_ff;
      fin_status_in = fin_status_ff;
      cmd.op        = OP_NONE;
      cmd.status    = fin_status_ff;
      req_ready     = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.mode == MODE_PUSH) begin
               if (st.full) begin
                  fin_status_in = STATUS_FULL;
                  state_in      = S_FINISH;
               end else begin
                  cmd.op   = OP_PUSH_START;
                  state_in = S_PUSH;
               end
            end else if (st.empty) begin
               fin_status_in = STATUS_EMPTY;
               state_in      = S_FINISH;
            end else begin
               cmd.op   = OP_SRCH_START;
               state_in = S_SEARCH;
            end
         end
         S_PUSH: begin
            cmd.op = OP_PUSH_STEP;
            if (st.push_done) begin
               fin_status_in = STATUS_OK;
               state_in      = S_FINISH;
            end
         end
         S_SEARCH: begin
            priority if (st.mode == MODE_PEEK && st.found) begin
               fin_status_in = STATUS_OK;
               state_in      = S_FINISH;
            end else if (st.walk_end) begin
               if (!st.found) begin
                  fin_status_in = STATUS_NOT_FOUND;
                  state_in      = S_FINISH;
               end else if (st.pos_zero) begin
                  fin_status_in = STATUS_OK;
                  state_in      = S_FINISH;
               end else begin
                  cmd.op   = OP_AGE_START;
                  state_in = S_AGE;
               end
            end else begin
               cmd.op = OP_SRCH_STEP;
            end
         end
         S_AGE: begin
            if (st.age_end) begin
               fin_status_in = STATUS_OK;
               state_in      = S_FINISH;
            end else begin
               cmd.op = OP_AGE_STEP;
            end
         end
         S_FINISH: begin
            if (!st.out_busy) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fin_status_ff <= STATUS_OK;
      end else begin
         state_ff      <= state_in;
         fin_status_ff <= fin_status_in;
      end
   end

endmodule

### sv/aspq_datapath.sv
// ----------------------------------------------------------------------------
// Aging sorted priority queue datapath
// Slot memory with one write and one registered read port, walk index,
// removed-entry capture, aging subtractor, count and time total, and the
// output register.
// ----------------------------------------------------------------------------
module aspq_datapath #(
   parameter int DEPTH    = 16,
   parameter int TAG_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aspq_pkg::cmd_type                 cmd,
   output aspq_pkg::stat_type                st,
   input  logic [aspq_pkg::MODE_W-1:0]       in_mode,
   input  logic [aspq_pkg::IO_TAG_W-1:0]     in_tag,
   input  logic [aspq_pkg::PRIO_W-1:0]       in_priority,
   input  logic [aspq_pkg::TIME_W-1:0]       in_time,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [aspq_pkg::STATUS_W-1:0]     out_status,
   output logic [aspq_pkg::IO_TAG_W-1:0]     out_tag,
   output logic [aspq_pkg::PRIO_W-1:0]       out_priority,
   output logic [aspq_pkg::TIME_W-1:0]       out_time,
   output logic [aspq_pkg::COUNT_W-1:0]      out_count,
   output logic [aspq_pkg::SUM_W-1:0]        out_total
);
   import aspq_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [TAG_BITS-1:0] mem_tag  [DEPTH];
   logic [PRIO_W-1:0]   mem_prio [DEPTH];
   logic [TIME_W-1:0]   mem_time [DEPTH];

   logic [TAG_BITS-1:0] rd_tag_ff;
   logic [PRIO_W-1:0]   rd_prio_ff;
   logic [TIME_W-1:0]   rd_time_ff;

   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [TAG_BITS-1:0] wr_tag;
   logic [PRIO_W-1:0]   wr_prio;
   logic [TIME_W-1:0]   wr_time;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [TAG_BITS-1:0] new_tag_ff, new_tag_in;
   logic [PRIO_W-1:0]   new_prio_ff, new_prio_in;
   logic [TIME_W-1:0]   new_time_ff, new_time_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                dv_ff, dv_in;
   logic [ADDR_W-1:0]   daddr_ff, daddr_in;
   logic                found_ff, found_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [TAG_BITS-1:0] rem_tag_ff, rem_tag_in;
   logic [PRIO_W-1:0]   rem_prio_ff, rem_prio_in;
   logic [TIME_W-1:0]   rem_time_ff, rem_time_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [IO_TAG_W-1:0] out_tag_ff, out_tag_in;
   logic [PRIO_W-1:0]   out_prio_ff, out_prio_in;
   logic [TIME_W-1:0]   out_time_ff, out_time_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic [SUM_W-1:0]    out_sum_ff, out_sum_in;

   logic [PRIO_W-1:0]   aged_prio;
   logic                hit;
   logic                lower;
   logic                push_done;
   logic                take_head;
   logic [CNT_W-1:0]    cnt_next;
   logic [SUM_W-1:0]    sum_next;

   assign aged_prio = (rd_prio_ff > rem_time_ff) ? (rd_prio_ff - rem_time_ff) : '0;
   assign hit       = (mode_ff == MODE_REMOVE) ? (rd_tag_ff == new_tag_ff) : 1'b1;
   assign lower     = (rd_prio_ff < new_prio_ff);

   always_comb begin
      mode_in       = mode_ff;
      new_tag_in    = new_tag_ff;
      new_prio_in   = new_prio_ff;
      new_time_in   = new_time_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      idx_in        = idx_ff;
      dv_in         = dv_ff;
      daddr_in      = daddr_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      rem_tag_in    = rem_tag_ff;
      rem_prio_in   = rem_prio_ff;
      rem_time_in   = rem_time_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_tag_in    = out_tag_ff;
      out_prio_in   = out_prio_ff;
      out_time_in   = out_time_ff;
      out_count_in  = out_count_ff;
      out_sum_in    = out_sum_ff;
      rd_addr       = idx_ff[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = daddr_ff;
      wr_tag        = rd_tag_ff;
      wr_prio       = rd_prio_ff;
      wr_time       = rd_time_ff;
      push_done     = 1'b0;
      take_head     = 1'b0;
      cnt_next      = count_ff;
      sum_next      = sum_ff;

      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            mode_in     = in_mode;
            new_tag_in  = TAG_BITS'(in_tag);
            new_prio_in = in_priority;
            new_time_in = in_time;
         end
         OP_PUSH_START: begin
            idx_in = count_ff;
            dv_in  = 1'b0;
         end
         OP_PUSH_STEP: begin
            rd_addr = ADDR_W'(idx_ff - 1'b1);
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(daddr_ff + 1'b1);
               if (lower) begin
                  wr_tag    = new_tag_ff;
                  wr_prio   = new_prio_ff;
                  wr_time   = new_time_ff;
                  push_done = 1'b1;
               end
            end else if (idx_ff == '0) begin
               wr_en     = 1'b1;
               wr_addr   = '0;
               wr_tag    = new_tag_ff;
               wr_prio   = new_prio_ff;
               wr_time   = new_time_ff;
               push_done = 1'b1;
            end
            if (idx_ff != '0) begin
               dv_in    = 1'b1;
               daddr_in = rd_addr;
               idx_in   = idx_ff - 1'b1;
            end else begin
               dv_in = 1'b0;
            end
         end
         OP_SRCH_START: begin
            idx_in   = '0;
            dv_in    = 1'b0;
            found_in = 1'b0;
         end
         OP_SRCH_STEP: begin
            if (dv_ff) begin
               if (!found_ff) begin
                  if (hit) begin
                     found_in    = 1'b1;
                     pos_in      = daddr_ff;
                     rem_tag_in  = rd_tag_ff;
                     rem_prio_in = rd_prio_ff;
                     rem_time_in = rd_time_ff;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(daddr_ff - 1'b1);
                  wr_prio = aged_prio;
               end
            end
            if (idx_ff < count_ff) begin
               dv_in    = 1'b1;
               daddr_in = idx_ff[ADDR_W-1:0];
               idx_in   = idx_ff + 1'b1;
            end else begin
               dv_in = 1'b0;
            end
         end
         OP_AGE_START: begin
            idx_in = '0;
            dv_in  = 1'b0;
         end
         OP_AGE_STEP: begin
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = daddr_ff;
               wr_prio = aged_prio;
            end
            if (idx_ff < CNT_W'(pos_ff)) begin
               dv_in    = 1'b1;
               daddr_in = idx_ff[ADDR_W-1:0];
               idx_in   = idx_ff + 1'b1;
            end else begin
               dv_in = 1'b0;
            end
         end
         OP_FINISH: begin
            if (cmd.status == STATUS_OK) begin
               unique case (mode_ff)
                  MODE_PUSH: begin
                     cnt_next = count_ff + 1'b1;
                     sum_next = sum_ff + SUM_W'(new_time_ff);
                  end
                  MODE_POP, MODE_REMOVE: begin
                     cnt_next  = count_ff - 1'b1;
                     sum_next  = sum_ff - SUM_W'(rem_time_ff);
                     take_head = 1'b1;
                  end
                  MODE_PEEK: begin
                     take_head = 1'b1;
                  end
               endcase
            end
            count_in      = cnt_next;
            sum_in        = sum_next;
            out_valid_in  = 1'b1;
            out_status_in = cmd.status;
            out_tag_in    = take_head ? IO_TAG_W'(rem_tag_ff) : '0;
            out_prio_in   = take_head ? rem_prio_ff : '0;
            out_time_in   = take_head ? rem_time_ff : '0;
            out_count_in  = COUNT_W'(cnt_next);
            out_sum_in    = sum_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_tag[wr_addr]  <= wr_tag;
         mem_prio[wr_addr] <= wr_prio;
         mem_time[wr_addr] <= wr_time;
      end
      rd_tag_ff  <= mem_tag[rd_addr];
      rd_prio_ff <= mem_prio[rd_addr];
      rd_time_ff <= mem_time[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff       <= mode_in;
      new_tag_ff    <= new_tag_in;
      new_prio_ff   <= new_prio_in;
      new_time_ff   <= new_time_in;
      daddr_ff      <= daddr_in;
      pos_ff        <= pos_in;
      rem_tag_ff    <= rem_tag_in;
      rem_prio_ff   <= rem_prio_in;
      rem_time_ff   <= rem_time_in;
      out_status_ff <= out_status_in;
      out_tag_ff    <= out_tag_in;
      out_prio_ff   <= out_prio_in;
      out_time_ff   <= out_time_in;
      out_count_ff  <= out_count_in;
      out_sum_ff    <= out_sum_in;
   end

   assign st.mode      = mode_ff;
   assign st.empty     = (count_ff == '0);
   assign st.full      = (count_ff == CNT_W'(DEPTH));
   assign st.push_done = push_done;
   assign st.found     = found_ff;
   assign st.walk_end  = (idx_ff == count_ff) && !dv_ff;
   assign st.pos_zero  = (pos_ff == '0);
   assign st.age_end   = (idx_ff == CNT_W'(pos_ff)) && !dv_ff;
   assign st.out_busy  = out_valid_ff && !out_ready;

   assign out_valid    = out_valid_ff;
   assign out_status   = out_status_ff;
   assign out_tag      = out_tag_ff;
   assign out_priority = out_prio_ff;
   assign out_time     = out_time_ff;
   assign out_count    = out_count_ff;
   assign out_total    = out_sum_ff;

endmodule

### bench/aging_sorted_priority_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging sorted priority queue unit testbench
// Sends push, pop, remove and peek requests through the request stream and
// checks every response against a behavioral copy of the queue held in the
// bench. The directed tests cover the empty and full queue, missing and
// duplicate tags, ordering among equal priorities and aging that clamps at
// zero. The random phases then run mixed traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module aging_sorted_priority_queue_unit_test;

   import aspq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IO_TAG_W-1:0] tag;
      logic [PRIO_W-1:0]   prio;
      logic [TIME_W-1:0]   svc;
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    total;
   } outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [MODE_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   logic [IO_TAG_W-1:0] queue_tag  [DEPTH];
   logic [PRIO_W-1:0]   queue_prio [DEPTH];
   logic [TIME_W-1:0]   queue_time [DEPTH];
   int                  queue_len;
   logic [SUM_W-1:0]    queue_sum;

   outcome_type expected_outcomes [$];
   outcome_type wanted;
   int          failures;
   int          cycle_count;
   int          idle_pct;
   int          stall_pct;

   aging_sorted_priority_queue_unit #(
      .DEPTH    (DEPTH),
      .TAG_BITS (8)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Deletes one slot and ages every entry left by the removed service time.
   task automatic retire_slot(input int pos);
      logic [TIME_W-1:0] spent;
      spent = queue_time[pos];
      for (int i = pos; i + 1 < queue_len; i++) begin
         queue_tag[i]  = queue_tag[i + 1];
         queue_prio[i] = queue_prio[i + 1];
         queue_time[i] = queue_time[i + 1];
      end
      queue_len--;
      queue_sum = queue_sum - SUM_W'(spent);
      for (int i = 0; i < queue_len; i++) begin
         queue_prio[i] = (queue_prio[i] > spent) ? queue_prio[i] - spent : '0;
      end
   endtask

   task automatic serve_request(input logic [MODE_W-1:0] mode, input logic [IO_TAG_W-1:0] tag,
                                input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] svc);
      outcome_type res;
      int          pos;
      res = '0;
      pos = 0;
      if (mode == MODE_PUSH) begin
         if (queue_len >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            while (pos < queue_len && queue_prio[pos] < prio) pos++;
            for (int i = queue_len; i > pos; i--) begin
               queue_tag[i]  = queue_tag[i - 1];
               queue_prio[i] = queue_prio[i - 1];
               queue_time[i] = queue_time[i - 1];
            end
            queue_tag[pos]  = tag;
            queue_prio[pos] = prio;
            queue_time[pos] = svc;
            queue_len++;
            queue_sum = queue_sum + SUM_W'(svc);
         end
      end else if (queue_len == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         if (mode == MODE_REMOVE) begin
            while (pos < queue_len && queue_tag[pos] != tag) pos++;
         end
         if (pos == queue_len) begin
            res.status = STATUS_NOT_FOUND;
         end else begin
            res.tag  = queue_tag[pos];
            res.prio = queue_prio[pos];
            res.svc  = queue_time[pos];
            if (mode != MODE_PEEK) retire_slot(pos);
         end
      end
      res.count = COUNT_W'(queue_len);
      res.total = queue_sum;
      expected_outcomes.push_back(res);
   endtask

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IO_TAG_W-1:0] tag,
                            input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] svc);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {svc, prio, tag};
      do @(posedge clock); while (!req_tready);
      serve_request(mode, tag, prio, svc);
   endtask

   task automatic test_empty_queue();
      send_item(MODE_PEEK, 8'h5A, 16'h1234, 16'h4321);
      send_item(MODE_POP, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000);
   endtask

   task automatic test_push_order();
      send_item(MODE_PUSH, 8'h00, 16'h0000, 16'h0000);
      send_item(MODE_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(MODE_PUSH, 8'h01, 16'd100, 16'd3);
      send_item(MODE_PUSH, 8'h02, 16'd100, 16'd5);
      send_item(MODE_PUSH, 8'h00, 16'h2AAA, 16'h5555);
      send_item(MODE_PEEK, 8'h00, 16'h0000, 16'h0000);
   endtask

   task automatic test_remove_and_pop();
      send_item(MODE_REMOVE, 8'd77, 16'h0000, 16'h0000);
      send_item(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000);
      send_item(MODE_POP, 8'h00, 16'h0000, 16'h0000);
      send_item(MODE_REMOVE, 8'hFF, 16'h0000, 16'h0000);
      send_item(MODE_PEEK, 8'h00, 16'h0000, 16'h0000);
   endtask

   task automatic test_full_queue();
      while (queue_len < DEPTH) begin
         send_item(MODE_PUSH, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
      end
      send_item(MODE_PUSH, 8'hA5, 16'h0001, 16'h0001);
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int items);
      int                  push_weight;
      int                  pick;
      logic [MODE_W-1:0]   mode;
      logic [IO_TAG_W-1:0] tag;
      logic [PRIO_W-1:0]   prio;
      logic [TIME_W-1:0]   svc;
      idle_pct    = idle;
      stall_pct   = stall;
      push_weight = 50;
      for (int n = 0; n < items; n++) begin
         if (n % 30 == 0) push_weight = $urandom_range(85, 15);
         if ($urandom_range(99) < push_weight) begin
            mode = MODE_PUSH;
         end else begin
            pick = $urandom_range(9);
            mode = (pick < 4) ? MODE_POP : (pick < 8) ? MODE_REMOVE : MODE_PEEK;
         end
         tag = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
         if (mode == MODE_REMOVE && queue_len > 0 && $urandom_range(3) != 0) begin
            tag = queue_tag[$urandom_range(queue_len - 1)];
         end
         case ($urandom_range(3))
            0: prio = 16'($urandom_range(65535));
            1: prio = 16'($urandom_range(63));
            2: prio = (queue_len > 0) ? queue_prio[$urandom_range(queue_len - 1)]
                                      : 16'($urandom_range(65535));
            default: prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         endcase
         case ($urandom_range(3))
            0, 1: svc = 16'($urandom_range(15));
            2: svc = 16'($urandom_range(1023));
            default: svc = 16'($urandom_range(65535));
         endcase
         send_item(mode, tag, prio, svc);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want_value,
                              input logic [31:0] got_value);
      if (want_value !== got_value) begin
         $error("%s: expected %0h, got %0h", name, want_value, got_value);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $error("response transaction with no request waiting");
            failures++;
         end else begin
            wanted = expected_outcomes.pop_front();
            check_field("status", wanted.status, rsp_tuser);
            check_field("head_tag", wanted.tag, rsp_tdata[7:0]);
            check_field("head_priority", wanted.prio, rsp_tdata[23:8]);
            check_field("head_time", wanted.svc, rsp_tdata[39:24]);
            check_field("entry_count", wanted.count, rsp_tdata[44:40]);
            check_field("total_time", wanted.total, rsp_tdata[64:45]);
            check_field("padding", 32'd0, rsp_tdata[71:65]);
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("aging_sorted_priority_queue_unit_test failed");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_PUSH;
      rsp_tready  = 1'b0;
      queue_len   = 0;
      queue_sum   = '0;
      failures    = 0;
      cycle_count = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_push_order();
      test_remove_and_pop();
      test_full_queue();
      test_random_traffic(0, 0, 180);
      test_random_traffic(53, 0, 180);
      test_random_traffic(0, 53, 180);
      test_random_traffic(10, 10, 180);

      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0) begin
         $display("aging_sorted_priority_queue_unit_test passed");
      end else begin
         $display("aging_sorted_priority_queue_unit_test failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/aspq_pkg.sv
sv/aspq_ctrl.sv
sv/aspq_datapath.sv
sv/aging_sorted_priority_queue_unit.sv
bench/aging_sorted_priority_queue_unit_test.sv
